### rtl/pafc_pkg.sv
// Shared types and constants of the poll answer frame checker.
// Used by every module of the block; depends on nothing.
package pafc_pkg;

    // Frame bytes and check marks.
    localparam logic [7:0] ETX_BYTE    = 8'h03;
    localparam logic [7:0] ADDR_OFFSET = 8'h40;
    localparam logic [7:0] CHECK_MARK  = 8'h80;

    // Payload length field saturates here.
    localparam int unsigned LEN_W   = 10;
    localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;

    // Configuration port.
    localparam int unsigned CFG_W     = 11;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY    = 1'd1;
    localparam logic [CFG_W-1:0] MAX_FRAME_BYTES_RST = 11'd256;
    localparam logic [CFG_W-1:0] OUT_CAPACITY_RST    = 11'd256;
    localparam logic [CFG_W-1:0] MIN_FRAME_BYTES     = 11'd3;

    // Default upper bound on the frame limit.
    localparam int unsigned MAX_FRAME_LIMIT_DEF = 1024;

    // Frame status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_CHECK_FAIL = 3'd1;
    localparam logic [2:0] ST_WRONG_SLV  = 3'd2;
    localparam logic [2:0] ST_NO_TERM    = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;
    localparam logic [2:0] ST_EMPTY      = 3'd5;

    // Receive phases.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_RECV  = 2'd1;
    localparam logic [1:0] PH_CHECK = 2'd2;

    typedef struct packed {
        logic       first_byte;
        logic [4:0] expected_slave;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic             is_status;
        logic [7:0]       payload_byte;
        logic [2:0]       frame_status;
        logic [LEN_W-1:0] payload_length;
        logic             frame_last;
    } out_item_t;

    // Handshake between a producing and a consuming stage.
    typedef struct packed {
        logic valid;
        logic take;
    } stage_hs_t;

endpackage

### rtl/pafc_in_stage.sv
// Input register of the poll answer frame checker.
// Holds one accepted beat until the frame logic takes it; uses pafc_pkg.
module pafc_in_stage
    import pafc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    input  logic      take,
    output logic      item_valid,
    output in_item_t  item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;
    logic     accept;

    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

### rtl/pafc_frame_core.sv
// Frame state and per-byte decision logic of the poll answer frame checker.
// Tracks phase, check accumulator, byte count and address match; uses pafc_pkg.
module pafc_frame_core
    import pafc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_LIMIT = MAX_FRAME_LIMIT_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] max_frame_bytes,
    input  logic [CFG_W-1:0] out_capacity,
    input  in_item_t         item,
    input  stage_hs_t        hs,
    output logic             res_valid,
    output out_item_t        res
);

    // Byte count never passes the frame limit.
    localparam int unsigned CW = $clog2(MAX_FRAME_LIMIT + 1);
    // Common compare width for counts and register values.
    localparam int unsigned WW = ((CW > CFG_W) ? CW : CFG_W) + 1;

    logic [1:0]    phase_reg, phase_next;
    logic [7:0]    acc_reg, acc_next;
    logic [CW-1:0] count_reg, count_next;
    logic          match_reg, match_next;

    logic [WW-1:0] limit;
    logic [WW-1:0] cap_w;
    logic [WW-1:0] count_w;
    logic [WW-1:0] pidx;
    logic [WW-1:0] count_inc;
    logic [WW-1:0] check_len;
    logic [7:0]    rx;
    logic          is_etx;

    function automatic out_item_t status_item(input logic [2:0] st, input logic [WW-1:0] n);
        out_item_t r;
        r                = '0;
        r.is_status      = 1'b1;
        r.frame_status   = st;
        r.payload_length = (n > WW'(LEN_MAX)) ? LEN_W'(LEN_MAX) : n[LEN_W-1:0];
        r.frame_last     = 1'b1;
        return r;
    endfunction

    always_comb
    begin
        if ({1'b0, max_frame_bytes} < {1'b0, MIN_FRAME_BYTES})
        begin
            limit = WW'(MIN_FRAME_BYTES);
        end
        else if (WW'(max_frame_bytes) > WW'(MAX_FRAME_LIMIT))
        begin
            limit = WW'(MAX_FRAME_LIMIT);
        end
        else
        begin
            limit = WW'(max_frame_bytes);
        end
    end

    assign cap_w     = WW'(out_capacity);
    assign count_w   = WW'(count_reg);
    assign pidx      = count_w - WW'(1);
    assign count_inc = count_w + WW'(1);
    assign check_len = (count_w >= WW'(2)) ? (count_w - WW'(2)) : '0;
    assign rx        = item.rx_byte;
    assign is_etx    = (rx == ETX_BYTE);

    always_comb
    begin
        res_valid  = 1'b0;
        res        = '0;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        match_next = match_reg;
        if (item.first_byte)
        begin
            // Address byte: a restart drops any frame in progress.
            match_next = (rx == (ADDR_OFFSET + {3'b000, item.expected_slave}));
            acc_next   = rx;
            count_next = CW'(1);
            phase_next = is_etx ? PH_CHECK : PH_RECV;
        end
        else
        begin
            unique case (phase_reg)
                PH_CHECK:
                begin
                    res_valid  = 1'b1;
                    phase_next = PH_IDLE;
                    if (!match_reg)
                    begin
                        res = status_item(ST_WRONG_SLV, check_len);
                    end
                    else if (check_len > cap_w)
                    begin
                        res = status_item(ST_TOO_LONG, check_len);
                    end
                    else if (rx != (acc_reg | CHECK_MARK))
                    begin
                        res = status_item(ST_CHECK_FAIL, check_len);
                    end
                    else if (check_len == '0)
                    begin
                        res = status_item(ST_EMPTY, check_len);
                    end
                    else
                    begin
                        res = status_item(ST_OK, check_len);
                    end
                end
                PH_RECV:
                begin
                    count_next = CW'(count_inc);
                    acc_next   = acc_reg ^ rx;
                    if (is_etx && (count_inc < limit))
                    begin
                        phase_next = PH_CHECK;
                    end
                    else if (count_inc >= limit)
                    begin
                        // Frame limit reached without room for a check byte.
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                        res = status_item(match_reg ? ST_NO_TERM : ST_WRONG_SLV,
                                          is_etx ? pidx : count_w);
                    end
                    else if (match_reg && (pidx < cap_w))
                    begin
                        res_valid        = 1'b1;
                        res.payload_byte = rx;
                    end
                end
                default:
                begin
                    // Stray byte while idle is dropped.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            count_reg <= '0;
            match_reg <= 1'b0;
        end
        else if (hs.valid && hs.take)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            match_reg <= match_next;
        end
    end

endmodule

### rtl/pafc_out_stage.sv
// Result register of the poll answer frame checker.
// Holds one result beat while the output is stalled; uses pafc_pkg.
module pafc_out_stage
    import pafc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t res,
    output logic      free,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/poll_answer_frame_checker.sv
// Poll answer frame checker: checks the bytes that follow STX (address,
// payload, ETX, XOR check byte), passes payload bytes on and ends each frame
// with one status beat. Depends on pafc_pkg and the pafc_* stage modules.
//
// One input beat is taken every cycle when the output is not stalled. A beat
// is held in the input register, is decided by the frame logic, and its
// result (if any) is written into the result register, which drives
// out_valid. Beats that give no result pass even while the output is stalled.
// The configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while no frame byte is in flight, the block does not enforce it.
module poll_answer_frame_checker
    import pafc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_LIMIT = MAX_FRAME_LIMIT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] max_frame_bytes_reg;
    logic [CFG_W-1:0] out_capacity_reg;

    logic      item_valid;
    in_item_t  item;
    stage_hs_t hs;
    logic      res_valid;
    out_item_t res;
    logic      out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_bytes_reg <= MAX_FRAME_BYTES_RST;
            out_capacity_reg    <= OUT_CAPACITY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_FRAME_BYTES: max_frame_bytes_reg <= cfg_data;
                CFG_OUT_CAPACITY:    out_capacity_reg    <= cfg_data;
                default:             ;
            endcase
        end
    end

    // A beat moves on unless it has a result and the result register is full and stalled.
    assign hs.valid = item_valid;
    assign hs.take  = item_valid && (!res_valid || out_free);

    pafc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .take       (hs.take),
        .item_valid (item_valid),
        .item       (item)
    );

    pafc_frame_core #(
        .MAX_FRAME_LIMIT (MAX_FRAME_LIMIT)
    ) u_frame_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_frame_bytes (max_frame_bytes_reg),
        .out_capacity    (out_capacity_reg),
        .item            (item),
        .hs              (hs),
        .res_valid       (res_valid),
        .res             (res)
    );

    pafc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (hs.take && res_valid),
        .res       (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### test/tb_poll_answer_frame_checker.sv
// Self-checking testbench for poll_answer_frame_checker: frames of address, payload, ETX
// and check byte go in with random gaps and stalls; every beat is predicted and compared.
// Depends on pafc_pkg and the RTL of the block only.
module tb_poll_answer_frame_checker;
    import pafc_pkg::*;

    localparam int unsigned BEATS_PER_PHASE = 75;
    localparam int unsigned N_PHASES        = 9;

    logic            clk;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_stall;
    in_item_t        in_data   = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    out_item_t       out_data;
    logic            cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_FRAME_BYTES;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Register shadows and frame state of the predictor.
    logic [CFG_W-1:0] cfg_frame_bytes = MAX_FRAME_BYTES_RST;
    logic [CFG_W-1:0] cfg_out_cap     = OUT_CAPACITY_RST;
    logic [1:0]       rx_phase        = PH_IDLE;
    logic [7:0]       xor_acc         = '0;
    logic [10:0]      byte_cnt        = '0;
    logic             addr_ok         = 1'b0;

    in_item_t    pending_beats[$];
    out_item_t   frame_results_q[$];
    int unsigned mismatches  = 0;
    int unsigned phase_beats = 0;
    int unsigned in_gap      = 0;
    int unsigned out_hold    = 0;
    bit          no_idle     = 1'b0;

    poll_answer_frame_checker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned eff_frame_limit(logic [CFG_W-1:0] setting);
        int unsigned lim;
        lim = 32'(setting);
        if (lim < MIN_FRAME_BYTES)
            lim = 32'(MIN_FRAME_BYTES);
        if (lim > MAX_FRAME_LIMIT_DEF)
            lim = MAX_FRAME_LIMIT_DEF;
        return lim;
    endfunction

    // Mostly short gaps, a few long ones, none at all during a quiet phase.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(12, 30);
    endfunction

    function automatic void end_frame(logic [2:0] st, logic [10:0] len);
        out_item_t res;
        res                = '0;
        res.is_status      = 1'b1;
        res.frame_status   = st;
        res.payload_length = (len > LEN_MAX) ? '1 : len[LEN_W-1:0];
        res.frame_last     = 1'b1;
        frame_results_q.push_back(res);
        rx_phase = PH_IDLE;
    endfunction

    function automatic void track_frame_byte(in_item_t beat);
        int unsigned lim;
        logic [10:0] pidx;
        logic [10:0] len;
        out_item_t   res;
        lim = eff_frame_limit(cfg_frame_bytes);
        if (beat.first_byte)
        begin
            addr_ok  = (beat.rx_byte == ({3'b000, beat.expected_slave} + ADDR_OFFSET));
            xor_acc  = beat.rx_byte;
            byte_cnt = 11'd1;
            rx_phase = (beat.rx_byte == ETX_BYTE) ? PH_CHECK : PH_RECV;
        end
        else if (rx_phase == PH_CHECK)
        begin
            len = (byte_cnt >= 2) ? byte_cnt - 11'd2 : 11'd0;
            if (!addr_ok)
                end_frame(ST_WRONG_SLV, len);
            else if (len > cfg_out_cap)
                end_frame(ST_TOO_LONG, len);
            else if (beat.rx_byte != (xor_acc | CHECK_MARK))
                end_frame(ST_CHECK_FAIL, len);
            else if (len == 0)
                end_frame(ST_EMPTY, len);
            else
                end_frame(ST_OK, len);
        end
        else if (rx_phase == PH_RECV)
        begin
            pidx     = byte_cnt - 11'd1;
            byte_cnt = byte_cnt + 11'd1;
            xor_acc  = xor_acc ^ beat.rx_byte;
            if (beat.rx_byte == ETX_BYTE && byte_cnt < lim)
                rx_phase = PH_CHECK;
            else if (byte_cnt >= lim)
                end_frame(addr_ok ? ST_NO_TERM : ST_WRONG_SLV,
                          (beat.rx_byte == ETX_BYTE) ? pidx : pidx + 11'd1);
            else if (addr_ok && pidx < cfg_out_cap)
            begin
                res              = '0;
                res.payload_byte = beat.rx_byte;
                frame_results_q.push_back(res);
            end
        end
    endfunction

    // Driver: a beat is taken at each edge with valid high and stall low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                track_frame_byte(in_data);
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap--;
                end
                else if (pending_beats.size() > 0)
                begin
                    in_data  <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                    in_gap = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        end
    endtask

    // Monitor: checks result beats and drives a random stall.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_hold = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (frame_results_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat %h with nothing expected", $time, out_data);
                end
                else
                begin
                    want = frame_results_q.pop_front();
                    check_field("is_status", 16'(want.is_status), 16'(out_data.is_status));
                    check_field("payload_byte", 16'(want.payload_byte),
                                16'(out_data.payload_byte));
                    check_field("frame_status", 16'(want.frame_status),
                                16'(out_data.frame_status));
                    check_field("payload_length", 16'(want.payload_length),
                                16'(out_data.payload_length));
                    check_field("frame_last", 16'(want.frame_last), 16'(out_data.frame_last));
                end
            end
            if (out_hold > 0)
            begin
                out_stall <= 1'b1;
                out_hold--;
            end
            else
            begin
                out_stall <= 1'b0;
                out_hold = pick_gap();
            end
        end
    end

    function automatic void add_beat(bit first, logic [4:0] slv, logic [7:0] b);
        in_item_t beat;
        beat.first_byte     = first;
        beat.expected_slave = slv;
        beat.rx_byte        = b;
        pending_beats.push_back(beat);
        phase_beats++;
    endfunction

    // One frame after STX; without the end it stops after the payload.
    function automatic void add_frame(logic [4:0] slv, bit bad_addr, int unsigned plen,
                                      bit bad_check, bit with_end);
        logic [7:0] addr;
        logic [7:0] acc;
        logic [7:0] b;
        addr = {3'b000, slv} + ADDR_OFFSET;
        if (bad_addr)
            addr = addr ^ 8'($urandom_range(1, 255));
        acc = addr;
        add_beat(1'b1, slv, addr);
        for (int unsigned i = 0; i < plen; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == ETX_BYTE)
                b = b ^ 8'h10;
            acc = acc ^ b;
            add_beat(1'b0, 5'($urandom_range(0, 31)), b);
        end
        if (with_end)
        begin
            acc = acc ^ ETX_BYTE;
            add_beat(1'b0, 5'($urandom_range(0, 31)), ETX_BYTE);
            b = acc | CHECK_MARK;
            if (bad_check)
                b = b ^ 8'($urandom_range(1, 255));
            add_beat(1'b0, 5'($urandom_range(0, 31)), b);
        end
    endfunction

    function automatic void add_random_frame();
        int unsigned lim;
        int unsigned plen;
        int unsigned r;
        logic [4:0]  slv;
        lim  = eff_frame_limit(cfg_frame_bytes);
        slv  = 5'($urandom_range(0, 31));
        plen = $urandom_range(0, (lim - 3 < 16) ? lim - 3 : 16);
        if ($urandom_range(0, 3) == 0)
            plen = $urandom_range(0, (lim - 3 < 40) ? lim - 3 : 40);
        r = $urandom_range(0, 99);
        if (r < 60)
            add_frame(slv, 1'b0, plen, 1'b0, 1'b1);
        else if (r < 68)
            add_frame(slv, 1'b0, plen, 1'b1, 1'b1);
        else if (r < 76)
            add_frame(slv, 1'b1, plen, 1'($urandom_range(0, 1)), 1'b1);
        else if (r < 82 && lim <= 64)
            add_frame(slv, $urandom_range(0, 3) == 0, lim - 1, 1'b0, 1'b0);
        else if (r < 87 && lim <= 64)
            // The ETX is the last byte the limit allows, with no room for the check byte.
            add_frame(slv, 1'b0, lim - 2, 1'b0, 1'b1);
        else if (r < 91)
            add_frame(slv, 1'b0, (lim - 3 <= 40) ? lim - 3 : plen, 1'b0, 1'b1);
        else if (r < 96)
            // Cut short; the next first byte drops it without a result.
            add_frame(slv, 1'b0, (plen < lim - 2) ? plen : lim - 2, 1'b0, 1'b0);
        else
            repeat ($urandom_range(1, 4))
                add_beat($urandom_range(0, 7) == 0, 5'($urandom_range(0, 31)),
                         8'($urandom_range(0, 255)));
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_FRAME_BYTES)
            cfg_frame_bytes = value;
        else
            cfg_out_cap = value;
    endtask

    // Sampled at the falling edge so the driver's edge updates have settled.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || frame_results_q.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        logic [CFG_W-1:0] frame_set[N_PHASES];
        logic [CFG_W-1:0] cap_set[N_PHASES];
        bit               long_frame_sent;
        long_frame_sent = 1'b0;
        frame_set = '{11'd256, 11'd0, 11'd2047, 11'd3, 11'd1, 11'd12, 11'd1024, 11'd2, 11'd0};
        cap_set   = '{11'd256, 11'd0, 11'd2047, 11'd1, 11'd1024, 11'd4, 11'd5, 11'd2, 11'd0};
        frame_set[N_PHASES-1] = 11'($urandom_range(3, 40));
        cap_set[N_PHASES-1]   = 11'($urandom_range(0, 20));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames under the reset settings.
        add_beat(1'b0, 5'd0, 8'hFF);                           // stray byte while idle
        add_beat(1'b1, 5'd31, 8'h5F);                          // highest slave id
        add_beat(1'b0, 5'd31, 8'h00);
        add_beat(1'b0, 5'd31, 8'hFF);
        add_beat(1'b0, 5'd31, ETX_BYTE);
        add_beat(1'b0, 5'd31, 8'hA3);                          // 5F ^ 00 ^ FF ^ 03, bit 7 set
        add_frame(5'd0, 1'b0, 0, 1'b0, 1'b1);                  // empty payload
        add_frame(5'd5, 1'b0, 1, 1'b1, 1'b1);                  // bad check byte
        add_beat(1'b1, 5'd0, 8'h41);                           // wrong slave
        add_beat(1'b0, 5'd0, 8'h7E);
        add_beat(1'b0, 5'd0, ETX_BYTE);
        add_beat(1'b0, 5'd0, 8'hBE);
        add_beat(1'b1, 5'd9, ETX_BYTE);                        // address byte is the ETX
        add_beat(1'b0, 5'd9, 8'h83);
        add_frame(5'd17, 1'b0, 2, 1'b0, 1'b0);                 // restart drops this frame
        add_frame(5'd17, 1'b0, 1, 1'b0, 1'b1);

        for (int unsigned ph = 0; ph < N_PHASES; ph++)
        begin
            wait_idle();
            if (ph > 0)
            begin
                write_reg(CFG_MAX_FRAME_BYTES, frame_set[ph]);
                write_reg(CFG_OUT_CAPACITY, cap_set[ph]);
            end
            no_idle = ($urandom_range(0, 3) == 0);
            @(negedge clk);
            if (ph > 0)
                phase_beats = 0;
            // A single frame that runs into the largest frame limit.
            if (!long_frame_sent && eff_frame_limit(cfg_frame_bytes) == MAX_FRAME_LIMIT_DEF)
            begin
                add_frame(5'($urandom_range(0, 31)), 1'b0, MAX_FRAME_LIMIT_DEF - 1,
                          1'b0, 1'b0);
                long_frame_sent = 1'b1;
            end
            while (phase_beats < BEATS_PER_PHASE)
                add_random_frame();
        end
        wait_idle();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #12000000;
        $display("FAIL");
        $finish;
    end

endmodule
